/* rtl/mat4mul_pkg.sv */
// mat4mul_pkg: shared types of the 4x4 matrix multiplier
// no dependencies; used by matrix4_multiply
`default_nettype none

package mat4mul_pkg;

  // tag carried down the multiply-accumulate pipeline with each term
  typedef struct packed {
    logic first;     // first term of a dot product, loads the accumulator
    logic lastterm;  // last term of a dot product, result is complete
    logic lastel;    // term belongs to the final product element of a run
  } mat4mul_tag_t;

endpackage : mat4mul_pkg

`default_nettype wire

/* rtl/mat4mul_if.sv */
// mat4mul_if: valid/ready channels of the matrix multiplier
// input channel carries an element pair, output channel a product element
`default_nettype none

interface mat4mul_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a_element;
  logic signed [DATA_WIDTH-1:0] b_element;

  modport source (output valid, output a_element, output b_element, input ready);
  modport sink (input valid, input a_element, input b_element, output ready);
endinterface : mat4mul_in_if

interface mat4mul_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] product_element;
  logic                         last;

  modport source (output valid, output product_element, output last, input ready);
  modport sink (input valid, input product_element, input last, output ready);
endinterface : mat4mul_out_if

`default_nettype wire

/* rtl/matrix4_multiply.sv */
// matrix4_multiply: DIM x DIM signed fixed-point matrix product, one shared MAC
// depends on mat4mul_pkg and the channel interfaces in mat4mul_if.sv
`default_nettype none

// The block takes DIM*DIM element pairs (A and B at the same position, column-major),
// one per cycle while in_i.ready is high, then computes P = A * B with a single
// multiply-accumulate unit and sends the DIM*DIM elements of P in column-major order,
// with last set on the final one. Numbers are signed fixed point with DATA_WIDTH/2
// fraction bits (Q16.16 by default). Each dot product is summed at full width, shifted
// right arithmetically (truncation toward minus infinity) and saturated to DATA_WIDTH
// bits. The load phase and the multiply-accumulate phase of a run follow each other;
// no element pair is taken while the shared MAC, fed by one read port on each element
// store, works through the terms. Each term passes the read registers and the product
// register, and a finished dot product is saturated into the output register. Loading
// of the next run begins as soon as the last MAC term has been issued, so the pipeline
// drain overlaps the next load. Output stalls freeze the MAC pipeline.

module matrix4_multiply #(
  parameter int DIM        = 4,
  parameter int DATA_WIDTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mat4mul_in_if.sink  in_i,
  mat4mul_out_if.source out_o
);
  import mat4mul_pkg::*;

  localparam int NELEM  = DIM * DIM;
  localparam int IDX_W  = $clog2(NELEM);
  localparam int CNT_W  = $clog2(DIM);
  localparam int FRAC   = DATA_WIDTH / 2;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;
  localparam int SH_W   = ACC_W - FRAC;

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } state_e;

  // sequencer state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0] j_q, j_d;      // term index within a dot product
  logic [CNT_W-1:0] row_q, row_d;  // row of the product element
  logic [CNT_W-1:0] col_q, col_d;  // column of the product element

  // pipeline
  logic                         s1_valid_q, s2_valid_q;
  mat4mul_tag_t                 s0_tag, s1_tag_q, s2_tag_q;
  logic signed [DATA_WIDTH-1:0] a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [ACC_W-1:0]      acc_q, acc_sum;
  logic signed [SH_W-1:0]       acc_sh;
  logic signed [DATA_WIDTH-1:0] sat_val;

  // output register
  logic                         out_valid_q;
  logic signed [DATA_WIDTH-1:0] out_data_q;
  logic                         out_last_q;

  // element stores, written during load, read during run
  logic signed [DATA_WIDTH-1:0] a_mem [NELEM];
  logic signed [DATA_WIDTH-1:0] b_mem [NELEM];

  logic             load_xfer;
  logic             issue;
  logic             advance;
  logic             done_term;
  logic             last_issue;
  logic [IDX_W-1:0] a_addr, b_addr;

  assign in_i.ready = (state_q == ST_LOAD);
  assign load_xfer  = in_i.valid && in_i.ready;

  // a finished element stalls everything while the output register is full and not taken
  assign done_term = s2_valid_q && s2_tag_q.lastterm;
  assign advance   = !(done_term && out_valid_q && !out_o.ready);
  assign issue     = (state_q == ST_RUN) && advance;

  // A(row, j) and B(j, col), column-major
  assign a_addr = IDX_W'(j_q) * IDX_W'(DIM) + IDX_W'(row_q);
  assign b_addr = IDX_W'(col_q) * IDX_W'(DIM) + IDX_W'(j_q);

  assign last_issue = (j_q == CNT_W'(DIM - 1)) && (row_q == CNT_W'(DIM - 1))
                      && (col_q == CNT_W'(DIM - 1));

  always_comb begin
    s0_tag.first    = (j_q == '0);
    s0_tag.lastterm = (j_q == CNT_W'(DIM - 1));
    s0_tag.lastel   = (row_q == CNT_W'(DIM - 1)) && (col_q == CNT_W'(DIM - 1));
  end

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    j_d        = j_q;
    row_d      = row_q;
    col_d      = col_q;
    unique case (state_q)
      ST_LOAD: begin
        if (load_xfer) begin
          if (load_cnt_q == IDX_W'(NELEM - 1)) begin
            load_cnt_d = '0;
            state_d    = ST_RUN;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          // walk terms, then rows, then columns
          if (j_q == CNT_W'(DIM - 1)) begin
            j_d = '0;
            if (row_q == CNT_W'(DIM - 1)) begin
              row_d = '0;
              if (col_q == CNT_W'(DIM - 1)) begin
                col_d = '0;
              end else begin
                col_d = col_q + 1'b1;
              end
            end else begin
              row_d = row_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
          if (last_issue) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      j_q         <= '0;
      row_q       <= '0;
      col_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      j_q        <= j_d;
      row_q      <= row_d;
      col_q      <= col_d;
      if (advance) begin
        s1_valid_q <= issue;
        s2_valid_q <= s1_valid_q;
      end
      if (advance && done_term) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // element stores with registered read
  always_ff @(posedge clk_i) begin
    if (load_xfer) begin
      a_mem[load_cnt_q] <= in_i.a_element;
    end
    if (issue) begin
      a_rd_q <= a_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_xfer) begin
      b_mem[load_cnt_q] <= in_i.b_element;
    end
    if (issue) begin
      b_rd_q <= b_mem[b_addr];
    end
  end

  // shared multiplier and accumulator
  assign acc_sum = s2_tag_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
  assign acc_sh  = SH_W'(acc_sum >>> FRAC);

  // saturate: all bits from the target sign bit upward must agree
  always_comb begin
    if ((&acc_sh[SH_W-1:DATA_WIDTH-1]) || !(|acc_sh[SH_W-1:DATA_WIDTH-1])) begin
      sat_val = acc_sh[DATA_WIDTH-1:0];
    end else if (acc_sh[SH_W-1]) begin
      sat_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_tag_q <= s0_tag;
      s2_tag_q <= s1_tag_q;
      prod_q   <= a_rd_q * b_rd_q;
      if (s2_valid_q) begin
        acc_q <= acc_sum;
      end
      if (done_term) begin
        out_data_q <= sat_val;
        out_last_q <= s2_tag_q.lastel;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.product_element = out_data_q;
  assign out_o.last            = out_last_q;

  // a completed load always starts the run with a fresh count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_xfer && load_cnt_q == IDX_W'(NELEM - 1)) |=> (state_q == ST_RUN && load_cnt_q == '0))
    else $error("run did not start after a full load");

  // a finished dot product that is allowed to advance lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_term && advance) |=> out_valid_q)
    else $error("finished product element was lost");

  // a first term moves from stage one to stage two together with its valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && advance && s1_tag_q.first) |=> (s2_valid_q && s2_tag_q.first))
    else $error("pipeline tag and valid fell out of step");

endmodule : matrix4_multiply

`default_nettype wire
